// File: rtl/skfc_pkg.sv
// shared constants for the scale keyed fifo cache table
package skfc_pkg;

    localparam int EDGE_W  = 16;
    localparam int SCALE_W = 32;
    localparam int SIDX_W  = 20;
    localparam int PAY_W   = 32;
    localparam int PROD_W  = 36;

    // round half away from zero on the q20.16 product
    localparam logic [PROD_W-1:0] ROUND_HALF = 36'd32768;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

endpackage

// File: rtl/skfc_entry_mem.sv
// entry storage: one write port, one registered read port
module skfc_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/scale_keyed_fifo_cache_table.sv
// scale keyed table, fully associative, oldest-added replacement
// lookup: the input beat passes quantize, key scan and decide before the result beat shows
// add: the input beat passes quantize, key scan, decide, then rank pass before the result beat shows
// one read port visiting one entry a cycle paces both passes; next beat taken in the cycle after the result leaves
// async reset (rst_n low) clears all valid bits and the internal entry count, not stored entries or outputs
module scale_keyed_fifo_cache_table #(
    parameter int ENTRIES = 16,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [skfc_pkg::EDGE_W-1:0]   long_edge,
    input  logic signed [skfc_pkg::SCALE_W-1:0] content_scale,
    input  logic [skfc_pkg::PAY_W-1:0]    payload_handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [skfc_pkg::PAY_W-1:0]    payload_out,
    output logic                          evicted,
    output logic [CW-1:0]                 entry_count
);

    import skfc_pkg::*;

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int RECW = EDGE_W + SIDX_W + PAY_W + RW;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [IW:0]   CNT_END  = (IW + 1)'(ENTRIES);
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_QUANT  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    // control state
    logic [2:0]         state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW:0]        cnt_reg, cnt_next;
    logic               look_reg, look_next;
    logic [IW-1:0]      look_idx_reg, look_idx_next;
    logic               match_reg, match_next;
    logic               free_found_reg, free_found_next;

    // item payload and scan results
    logic               act_reg, act_next;
    logic [EDGE_W-1:0]  edge_reg, edge_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [PAY_W-1:0]   pay_reg, pay_next;
    logic [SIDX_W-1:0]  sidx_reg, sidx_next;
    logic [IW-1:0]      match_slot_reg, match_slot_next;
    logic [RW-1:0]      match_rank_reg, match_rank_next;
    logic [PAY_W-1:0]   match_pay_reg, match_pay_next;
    logic [IW-1:0]      free_slot_reg, free_slot_next;
    logic [IW-1:0]      old_slot_reg, old_slot_next;
    logic [IW-1:0]      tgt_reg, tgt_next;
    logic [RW-1:0]      thr_reg, thr_next;
    logic [RW-1:0]      new_rank_reg, new_rank_next;
    logic               shift_reg, shift_next;
    logic               evict_reg, evict_next;
    logic               hit_reg, hit_next;
    logic [PAY_W-1:0]   pout_reg, pout_next;
    logic               evicted_reg, evicted_next;
    logic [CW-1:0]      count_out_reg, count_out_next;

    // memory port
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [RECW-1:0]    mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [RECW-1:0]    mem_rdata;

    logic [EDGE_W-1:0]  rd_edge;
    logic [SIDX_W-1:0]  rd_sidx;
    logic [PAY_W-1:0]   rd_pay;
    logic [RW-1:0]      rd_rank;
    logic               rd_vld;
    logic               issue;
    logic               full;
    logic [PROD_W-1:0]  prod;

    assign rd_rank = mem_rdata[RW-1:0];
    assign rd_pay  = mem_rdata[RW +: PAY_W];
    assign rd_sidx = mem_rdata[RW + PAY_W +: SIDX_W];
    assign rd_edge = mem_rdata[RW + PAY_W + SIDX_W +: EDGE_W];
    assign rd_vld  = valid_reg[look_idx_reg];
    assign issue   = (cnt_reg < CNT_END);
    assign full    = (count_reg == FULL_CNT);

    // scale * 20 as shift-add, plus half for rounding
    assign prod = ({4'b0, scale_reg} << 4) + ({4'b0, scale_reg} << 2) + ROUND_HALF;

    skfc_entry_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (RECW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        look_next       = 1'b0;
        look_idx_next   = look_idx_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        act_next        = act_reg;
        edge_next       = edge_reg;
        scale_next      = scale_reg;
        pay_next        = pay_reg;
        sidx_next       = sidx_reg;
        match_slot_next = match_slot_reg;
        match_rank_next = match_rank_reg;
        match_pay_next  = match_pay_reg;
        free_slot_next  = free_slot_reg;
        old_slot_next   = old_slot_reg;
        tgt_next        = tgt_reg;
        thr_next        = thr_reg;
        new_rank_next   = new_rank_reg;
        shift_next      = shift_reg;
        evict_next      = evict_reg;
        hit_next        = hit_reg;
        pout_next       = pout_reg;
        evicted_next    = evicted_reg;
        count_out_next  = count_out_reg;
        mem_we          = 1'b0;
        mem_waddr       = look_idx_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = issue ? cnt_reg[IW-1:0] : '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    edge_next  = long_edge;
                    scale_next = content_scale;
                    pay_next   = payload_handle;
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT:
            begin
                if (scale_reg == '0 || scale_reg[SCALE_W-1])
                begin
                    sidx_next = '0;
                end
                else
                begin
                    sidx_next = prod[PROD_W-1 -: SIDX_W];
                end
                cnt_next        = '0;
                match_next      = 1'b0;
                free_found_next = 1'b0;
                old_slot_next   = '0;
                state_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                look_next     = issue;
                look_idx_next = cnt_reg[IW-1:0];
                cnt_next      = cnt_reg + (IW + 1)'(issue);
                if (look_reg)
                begin
                    if (rd_vld && !match_reg && rd_edge == edge_reg && rd_sidx == sidx_reg)
                    begin
                        match_next      = 1'b1;
                        match_slot_next = look_idx_reg;
                        match_rank_next = rd_rank;
                        match_pay_next  = rd_pay;
                    end
                    if (!rd_vld && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = look_idx_reg;
                    end
                    if (rd_vld && rd_rank == '0)
                    begin
                        old_slot_next = look_idx_reg;
                    end
                    if (look_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (act_reg == ACT_LOOKUP)
                begin
                    hit_next       = match_reg;
                    pout_next      = match_reg ? match_pay_reg : '0;
                    evicted_next   = 1'b0;
                    count_out_next = count_reg;
                    state_next     = ST_DONE;
                end
                else
                begin
                    if (match_reg)
                    begin
                        tgt_next      = match_slot_reg;
                        thr_next      = match_rank_reg;
                        new_rank_next = RW'(count_reg - 1'b1);
                        shift_next    = 1'b1;
                        evict_next    = 1'b0;
                    end
                    else if (full)
                    begin
                        tgt_next      = old_slot_reg;
                        thr_next      = '0;
                        new_rank_next = RW'(count_reg - 1'b1);
                        shift_next    = 1'b1;
                        evict_next    = 1'b1;
                    end
                    else
                    begin
                        tgt_next      = free_slot_reg;
                        thr_next      = '0;
                        new_rank_next = RW'(count_reg);
                        shift_next    = 1'b0;
                        evict_next    = 1'b0;
                    end
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                look_next     = issue;
                look_idx_next = cnt_reg[IW-1:0];
                cnt_next      = cnt_reg + (IW + 1)'(issue);
                if (look_reg)
                begin
                    // the target slot takes the new record, newer ones close the rank gap
                    if (look_idx_reg == tgt_reg)
                    begin
                        mem_we                   = 1'b1;
                        mem_wdata                = {edge_reg, sidx_reg, pay_reg, new_rank_reg};
                        valid_next[look_idx_reg] = 1'b1;
                    end
                    else if (shift_reg && rd_vld && rd_rank > thr_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {mem_rdata[RECW-1:RW], rd_rank - 1'b1};
                    end
                    if (look_idx_reg == LAST_IDX)
                    begin
                        if (!match_reg && !full)
                        begin
                            count_next     = count_reg + 1'b1;
                            count_out_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            count_out_next = count_reg;
                        end
                        hit_next     = 1'b0;
                        pout_next    = '0;
                        evicted_next = evict_reg;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            cnt_reg        <= '0;
            look_reg       <= 1'b0;
            look_idx_reg   <= '0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            cnt_reg        <= cnt_next;
            look_reg       <= look_next;
            look_idx_reg   <= look_idx_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        edge_reg       <= edge_next;
        scale_reg      <= scale_next;
        pay_reg        <= pay_next;
        sidx_reg       <= sidx_next;
        match_slot_reg <= match_slot_next;
        match_rank_reg <= match_rank_next;
        match_pay_reg  <= match_pay_next;
        free_slot_reg  <= free_slot_next;
        old_slot_reg   <= old_slot_next;
        tgt_reg        <= tgt_next;
        thr_reg        <= thr_next;
        new_rank_reg   <= new_rank_next;
        shift_reg      <= shift_next;
        evict_reg      <= evict_next;
        hit_reg        <= hit_next;
        pout_reg       <= pout_next;
        evicted_reg    <= evicted_next;
        count_out_reg  <= count_out_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign hit         = hit_reg;
    assign payload_out = pout_reg;
    assign evicted     = evicted_reg;
    assign entry_count = count_out_reg;

endmodule

// File: rtl/skfc_checker.sv
// port-level checks for the scale keyed fifo cache table, bound to the top level
module skfc_checker #(
    parameter int ENTRIES = 16,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       hit,
    input logic [skfc_pkg::PAY_W-1:0] payload_out,
    input logic                       evicted,
    input logic [CW-1:0]              entry_count
);

    import skfc_pkg::*;

    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    // a hit beat never evicts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted)
        else $error("hit and evicted in one beat");

    // a miss or an add carries a zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> payload_out == '0)
        else $error("nonzero payload without hit");

    // eviction only happens with a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> entry_count == FULL_CNT)
        else $error("eviction with free space");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= FULL_CNT)
        else $error("entry count above capacity");

    // stalled result beat holds its payload and entry count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(payload_out) && $stable(entry_count))
        else $error("stalled result beat changed");

endmodule

bind scale_keyed_fifo_cache_table skfc_checker #(.ENTRIES(ENTRIES)) u_skfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .payload_out (payload_out),
    .evicted     (evicted),
    .entry_count (entry_count)
);
